/* src/uqsd_pkg.sv */
// uqsd_pkg: shared types, constants and byte decode functions for the
// url query string decoder; used by every module under src, no dependencies
package uqsd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] MAX_PAIRS_RESET = 8'd16;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [1:0] KIND_KEY_BYTE   = 2'd0;
    localparam logic [1:0] KIND_VALUE_BYTE = 2'd1;
    localparam logic [1:0] KIND_KEY_END    = 2'd2;
    localparam logic [1:0] KIND_PAIR_END   = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } byte_beat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] pair_index;
        logic       last_in_run;
    } res_beat_t;

    // results caused by one input byte, up to three
    typedef struct packed {
        logic [1:0]      res_count;
        logic [2:0][1:0] kind;
        logic [2:0][7:0] data;
        logic [7:0]      pair_index;
    } bundle_t;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
            r = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            r = 5'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46)
            r = 5'(c - 8'h41 + 8'd10);
        else
            r = 5'd16;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] r;
        ha = hex_val(a);
        hb = hex_val(b);
        if (is_ws(a) || a == CH_PLUS)
            r = hb[4] ? 8'd0 : {4'd0, hb[3:0]};
        else if (a == CH_MINUS)
            r = hb[4] ? 8'd0 : 8'd0 - {4'd0, hb[3:0]};
        else if (!ha[4])
            r = hb[4] ? {4'd0, ha[3:0]} : {ha[3:0], hb[3:0]};
        else
            r = 8'd0;
        return r;
    endfunction

endpackage

/* src/uqsd_front.sv */
// uqsd_front: accepts query string bytes, tracks pair and escape state and
// builds the bundle of results per byte; depends on uqsd_pkg
module uqsd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                byte_valid,
    input  uqsd_pkg::byte_beat_t byte_beat,
    input  logic                q_full,
    output logic                push,
    output uqsd_pkg::bundle_t   bundle
);
    import uqsd_pkg::*;

    typedef enum logic [1:0] {
        PH_BETWEEN,
        PH_KEY,
        PH_VALUE,
        PH_DROP
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [1:0] pend_cnt_reg;
    logic [1:0] pend_cnt_next;
    logic [7:0] pend_first_reg;
    logic [7:0] pend_first_next;
    logic [7:0] pairs_done_reg;
    logic [7:0] pairs_done_next;
    logic [7:0] max_pairs_reg;
    logic       accept;
    logic [1:0] n;
    logic [1:0] kind_sel;
    logic       eq;
    logic       eos;
    logic [7:0] b;

    assign accept = byte_valid && !q_full;
    assign b      = byte_beat.in_byte;
    assign eos    = byte_beat.end_of_string;

    always_comb
    begin
        phase_next      = phase_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_first_next = pend_first_reg;
        pairs_done_next = pairs_done_reg;
        n               = 2'd0;
        bundle          = '0;
        kind_sel        = KIND_KEY_BYTE;
        eq              = 1'b0;

        if (phase_reg == PH_BETWEEN && b != CH_AMP)
        begin
            if (pairs_done_reg >= max_pairs_reg)
                phase_next = PH_DROP;
            else
            begin
                phase_next    = PH_KEY;
                pend_cnt_next = 2'd0;
            end
        end

        if (phase_next == PH_KEY || phase_next == PH_VALUE)
        begin
            kind_sel = (phase_next == PH_KEY) ? KIND_KEY_BYTE : KIND_VALUE_BYTE;
            eq       = (phase_next == PH_KEY) && (b == CH_EQ);
            if (b == CH_AMP || eq)
            begin
                if (pend_cnt_next != 2'd0)
                begin
                    bundle.kind[n] = kind_sel;
                    bundle.data[n] = CH_PCT;
                    n = n + 2'd1;
                end
                if (pend_cnt_next == 2'd2)
                begin
                    bundle.kind[n] = kind_sel;
                    bundle.data[n] = plain(pend_first_next);
                    n = n + 2'd1;
                end
                pend_cnt_next = 2'd0;
                if (eq && !eos)
                begin
                    bundle.kind[n] = KIND_KEY_END;
                    n = n + 2'd1;
                    phase_next = PH_VALUE;
                end
                else
                begin
                    bundle.kind[n] = KIND_PAIR_END;
                    n = n + 2'd1;
                    pairs_done_next = pairs_done_reg + 8'd1;
                    phase_next = PH_BETWEEN;
                end
            end
            else
            begin
                case (pend_cnt_next)
                    2'd0:
                    begin
                        if (b == CH_PCT)
                            pend_cnt_next = 2'd1;
                        else
                        begin
                            bundle.kind[n] = kind_sel;
                            bundle.data[n] = plain(b);
                            n = n + 2'd1;
                        end
                    end
                    2'd1:
                    begin
                        pend_cnt_next   = 2'd2;
                        pend_first_next = b;
                    end
                    default:
                    begin
                        bundle.kind[n] = kind_sel;
                        bundle.data[n] = decode_pair(pend_first_next, b);
                        n = n + 2'd1;
                        pend_cnt_next = 2'd0;
                    end
                endcase
                if (eos)
                begin
                    if (pend_cnt_next != 2'd0)
                    begin
                        bundle.kind[n] = kind_sel;
                        bundle.data[n] = CH_PCT;
                        n = n + 2'd1;
                    end
                    if (pend_cnt_next == 2'd2)
                    begin
                        bundle.kind[n] = kind_sel;
                        bundle.data[n] = plain(pend_first_next);
                        n = n + 2'd1;
                    end
                    pend_cnt_next = 2'd0;
                    bundle.kind[n] = KIND_PAIR_END;
                    n = n + 2'd1;
                    pairs_done_next = pairs_done_reg + 8'd1;
                    phase_next = PH_BETWEEN;
                end
            end
        end

        if (eos)
        begin
            phase_next      = PH_BETWEEN;
            pend_cnt_next   = 2'd0;
            pend_first_next = 8'd0;
            pairs_done_next = 8'd0;
        end

        bundle.res_count  = n;
        bundle.pair_index = pairs_done_reg;
    end

    assign push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_BETWEEN;
            pend_cnt_reg   <= 2'd0;
            pend_first_reg <= 8'd0;
            pairs_done_reg <= 8'd0;
            max_pairs_reg  <= MAX_PAIRS_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                max_pairs_reg <= cfg_wr_data;
            if (accept)
            begin
                phase_reg      <= phase_next;
                pend_cnt_reg   <= pend_cnt_next;
                pend_first_reg <= pend_first_next;
                pairs_done_reg <= pairs_done_next;
            end
        end
    end

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BETWEEN || phase_reg == PH_DROP) |-> pend_cnt_reg == 2'd0)
        else $error("escape pending outside a key or value");

    a_pairs_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eos) |=> (pairs_done_reg == 8'd0 && phase_reg == PH_BETWEEN))
        else $error("end of string did not clear pair state");
`endif

endmodule

/* src/uqsd_queue.sv */
// uqsd_queue: short queue of result bundles between front and back end;
// depends on uqsd_pkg
module uqsd_queue #(
    parameter int DEPTH = uqsd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  uqsd_pkg::bundle_t push_data,
    input  logic              pop,
    output uqsd_pkg::bundle_t head,
    output logic              empty,
    output logic              full
);
    import uqsd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bundle_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("bundle pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("bundle popped from empty queue");
`endif

endmodule

/* src/uqsd_back.sv */
// uqsd_back: walks each queued bundle and drives one result beat per cycle,
// while res_stall is low, through an output register; depends on uqsd_pkg
module uqsd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uqsd_pkg::bundle_t    head,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output uqsd_pkg::res_beat_t  res_beat
);
    import uqsd_pkg::*;

    logic       res_valid_reg;
    res_beat_t  beat_reg;
    logic [1:0] sub_reg;
    logic       load;
    logic       take;
    logic       last;

    assign load = !res_valid_reg || !res_stall;
    assign take = load && !q_empty;
    assign last = (sub_reg == head.res_count - 2'd1);
    assign pop  = take && last;

    assign res_valid = res_valid_reg;
    assign res_beat  = beat_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg.kind        <= head.kind[sub_reg];
            beat_reg.data        <= head.data[sub_reg];
            beat_reg.pair_index  <= head.pair_index;
            beat_reg.last_in_run <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sub_reg       <= 2'd0;
        end
        else
        begin
            if (load)
                res_valid_reg <= !q_empty;
            if (pop)
                sub_reg <= 2'd0;
            else if (take)
                sub_reg <= sub_reg + 2'd1;
        end
    end

`ifndef SYNTH
    a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> sub_reg < head.res_count)
        else $error("result select beyond bundle");
`endif

endmodule

/* src/url_query_string_decoder.sv */
// url_query_string_decoder: top level; one query string byte per beat in,
// decoded key and value bytes with markers out. An accepted byte's bundle is
// written into the bundle queue if it holds results; its result beats leave
// through the output register. Throughput: one byte per cycle while the queue
// has room, one result beat per cycle at the output register while res_stall
// is low. Reset clears pair state and the queue and sets max_pairs to 16.
module url_query_string_decoder #(
    parameter int QUEUE_DEPTH = uqsd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  uqsd_pkg::byte_beat_t byte_beat,
    output logic                 res_valid,
    input  logic                 res_stall,
    output uqsd_pkg::res_beat_t  res_beat
);
    import uqsd_pkg::*;

    logic    push;
    logic    pop;
    logic    q_empty;
    logic    q_full;
    bundle_t push_data;
    bundle_t head;

    assign byte_stall = q_full;

    uqsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .byte_beat   (byte_beat),
        .q_full      (q_full),
        .push        (push),
        .bundle      (push_data)
    );

    uqsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    uqsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule

/* tb/sv/testbench.sv */
// testbench: streams query strings through url_query_string_decoder with random
// idling on both sides and checks every result beat against a directed table or a
// local decoder model; depends on uqsd_pkg and url_query_string_decoder from src
module testbench;

    import uqsd_pkg::*;

    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_CYCLES = 10;
    localparam int NUM_DIRECTED = 25;

    localparam res_beat_t NO_RES = '{default: '0};

    typedef enum logic [1:0] {BETWEEN_PAIRS, IN_KEY, IN_VALUE, DROPPING} parse_phase_t;

    typedef struct {
        logic [7:0] in_byte;
        logic       eos;
        logic       typed;
        int         count;
        res_beat_t  res [3];
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_beat_t byte_beat = '{default: '0};
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_beat_t  res_beat;

    // decoder model state
    logic [7:0]   limit_pairs = MAX_PAIRS_RESET;
    parse_phase_t parse_phase = BETWEEN_PAIRS;
    logic [1:0]   esc_count = 2'd0;
    logic [7:0]   esc_first = 8'd0;
    logic [7:0]   pair_count = 8'd0;
    res_beat_t    byte_results [$];

    res_beat_t     expected_results [$];
    res_beat_t     want;
    int            error_count = 0;
    int            src_idle_pct = 8;
    int            sink_idle_pct = 8;
    logic          hold_request = 1'b0;
    logic          hold_taken = 1'b0;
    int            hold_left = 0;
    directed_row_t directed_rows [NUM_DIRECTED];

    url_query_string_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_beat   (res_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic res_beat_t beat_of(input logic [1:0] k, input logic [7:0] d,
                                          input logic [7:0] idx, input logic last);
        res_beat_t r;
        r.kind = k;
        r.data = d;
        r.pair_index = idx;
        r.last_in_run = last;
        return r;
    endfunction

    // 16 marks a byte that is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return 5'(c[3:0] + 4'd9);
        return 5'd16;
    endfunction

    // strtol base 16 on the two bytes after a percent sign
    function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] hi;
        logic [4:0] lo;
        hi = hex_nibble(a);
        lo = hex_nibble(b);
        if (a == CH_SPACE || (a >= 8'd9 && a <= 8'd13) || a == CH_PLUS)
            return lo[4] ? 8'h00 : {4'h0, lo[3:0]};
        if (a == CH_MINUS)
            return lo[4] ? 8'h00 : 8'h00 - {4'h0, lo[3:0]};
        if (!hi[4])
            return lo[4] ? {4'h0, hi[3:0]} : {hi[3:0], lo[3:0]};
        return 8'h00;
    endfunction

    function automatic void note_result(input logic [1:0] k, input logic [7:0] d);
        byte_results.push_back(beat_of(k, d, pair_count, 1'b0));
    endfunction

    function automatic void flush_escape(input logic [1:0] k);
        if (esc_count >= 2'd1)
            note_result(k, CH_PCT);
        if (esc_count == 2'd2)
            note_result(k, (esc_first == CH_PLUS) ? CH_SPACE : esc_first);
        esc_count = 2'd0;
    endfunction

    function automatic void close_pair();
        note_result(KIND_PAIR_END, 8'd0);
        pair_count = pair_count + 8'd1;
        parse_phase = BETWEEN_PAIRS;
    endfunction

    // fills byte_results with the beats one input byte causes
    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        logic [1:0] k;
        logic       eq;
        byte_results.delete();
        if (parse_phase == BETWEEN_PAIRS && b != CH_AMP)
        begin
            if (pair_count >= limit_pairs)
                parse_phase = DROPPING;
            else
            begin
                parse_phase = IN_KEY;
                esc_count = 2'd0;
            end
        end
        if (parse_phase == IN_KEY || parse_phase == IN_VALUE)
        begin
            k = (parse_phase == IN_KEY) ? KIND_KEY_BYTE : KIND_VALUE_BYTE;
            eq = (parse_phase == IN_KEY) && (b == CH_EQ);
            if (b == CH_AMP || eq)
            begin
                flush_escape(k);
                if (eq && !eos)
                begin
                    note_result(KIND_KEY_END, 8'd0);
                    parse_phase = IN_VALUE;
                end
                else
                    close_pair();
            end
            else
            begin
                if (esc_count == 2'd0)
                begin
                    if (b == CH_PCT)
                        esc_count = 2'd1;
                    else
                        note_result(k, (b == CH_PLUS) ? CH_SPACE : b);
                end
                else if (esc_count == 2'd1)
                begin
                    esc_count = 2'd2;
                    esc_first = b;
                end
                else
                begin
                    note_result(k, escape_value(esc_first, b));
                    esc_count = 2'd0;
                end
                if (eos)
                begin
                    flush_escape(k);
                    close_pair();
                end
            end
        end
        if (eos)
        begin
            parse_phase = BETWEEN_PAIRS;
            esc_count = 2'd0;
            esc_first = 8'd0;
            pair_count = 8'd0;
        end
        if (byte_results.size() != 0)
            byte_results[byte_results.size() - 1].last_in_run = 1'b1;
    endfunction

    task automatic offer(input directed_row_t row);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat <= '{in_byte: row.in_byte, end_of_string: row.eos};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        decode_byte(row.in_byte, row.eos);
        if (row.typed)
        begin
            for (int i = 0; i < row.count; i++)
                expected_results.push_back(row.res[i]);
        end
        else
        begin
            foreach (byte_results[i])
                expected_results.push_back(byte_results[i]);
        end
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_pairs(input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_pairs = v;
    endtask

    function automatic logic [7:0] escape_char();
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return hex_set[$urandom_range(0, 21)];
            6: return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
            7: return CH_PLUS;
            8: return CH_MINUS;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic add_token(ref logic [7:0] text [$]);
        string word_set;
        word_set = "abcxyz0123456789ABF_.-~";
        case ($urandom_range(0, 9))
            0, 1, 2, 3: text.push_back(word_set[$urandom_range(0, 22)]);
            4: text.push_back(CH_PLUS);
            5, 6:
            begin
                text.push_back(CH_PCT);
                text.push_back(escape_char());
                text.push_back(escape_char());
            end
            7: text.push_back(CH_PCT);
            8: text.push_back(CH_EQ);
            default: text.push_back(8'($urandom_range(1, 255)));
        endcase
    endtask

    // one whole query string, mostly well formed, sometimes pure noise
    task automatic send_query(inout int sent);
        logic [7:0]    text [$];
        directed_row_t row;
        int            pairs;
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            pairs = $urandom_range(1, 5);
            for (int p = 0; p < pairs; p++)
            begin
                if (p != 0 || $urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 2)) text.push_back(CH_AMP);
                repeat ($urandom_range(0, 4)) add_token(text);
                if ($urandom_range(0, 3) != 0)
                begin
                    text.push_back(CH_EQ);
                    repeat ($urandom_range(0, 4)) add_token(text);
                end
            end
            if ($urandom_range(0, 5) == 0)
                text.push_back(CH_AMP);
        end
        if (text.size() == 0)
            text.push_back("k");
        row.typed = 1'b0;
        row.count = 0;
        foreach (text[i])
        begin
            row.in_byte = text[i];
            row.eos = (i == text.size() - 1);
            offer(row);
        end
        sent += text.size();
    endtask

    task automatic random_phase(input int target);
        int sent;
        sent = 0;
        while (sent < target)
            send_query(sent);
    endtask

    // result side: random stall plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected result beat: kind %0d data %h pair %0d last %0d",
                             res_beat.kind, res_beat.data, res_beat.pair_index,
                             res_beat.last_in_run);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_beat.kind !== want.kind || res_beat.data !== want.data ||
                    res_beat.pair_index !== want.pair_index ||
                    res_beat.last_in_run !== want.last_in_run)
                begin
                    if (error_count < 10)
                        $display(
                            "exp/act: kind %0d/%0d data %h/%h pair %0d/%0d last %0d/%0d",
                            want.kind, res_beat.kind, want.data, res_beat.data,
                            want.pair_index, res_beat.pair_index,
                            want.last_in_run, res_beat.last_in_run);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        directed_rows = '{
            '{"a",      1'b0, 1'b1, 1,
              '{beat_of(KIND_KEY_BYTE, "a", 8'd0, 1'b1), NO_RES, NO_RES}},
            '{CH_PLUS,  1'b0, 1'b1, 1,
              '{beat_of(KIND_KEY_BYTE, CH_SPACE, 8'd0, 1'b1), NO_RES, NO_RES}},
            '{CH_EQ,    1'b0, 1'b1, 1,
              '{beat_of(KIND_KEY_END, 8'd0, 8'd0, 1'b1), NO_RES, NO_RES}},
            '{CH_PCT,   1'b0, 1'b1, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"4",      1'b0, 1'b1, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"1",      1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_EQ,    1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_PCT,   1'b0, 1'b1, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"f",      1'b0, 1'b1, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_AMP,   1'b0, 1'b1, 3, '{beat_of(KIND_VALUE_BYTE, CH_PCT, 8'd0, 1'b0),
                                         beat_of(KIND_VALUE_BYTE, "f", 8'd0, 1'b0),
                                         beat_of(KIND_PAIR_END, 8'd0, 8'd0, 1'b1)}},
            '{CH_AMP,   1'b0, 1'b1, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_PCT,   1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_SPACE, 1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"B",      1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_PCT,   1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_MINUS, 1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"3",      1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_PCT,   1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"z",      1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"1",      1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{CH_PCT,   1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"7",      1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{"q",      1'b0, 1'b0, 0, '{NO_RES, NO_RES, NO_RES}},
            '{8'hFF,    1'b0, 1'b1, 1,
              '{beat_of(KIND_KEY_BYTE, 8'hFF, 8'd1, 1'b1), NO_RES, NO_RES}},
            '{CH_EQ,    1'b1, 1'b1, 1,
              '{beat_of(KIND_PAIR_END, 8'd0, 8'd1, 1'b1), NO_RES, NO_RES}}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i]);
        drain();

        write_max_pairs(8'd1);
        random_phase(30);
        drain();

        // no idling on either side
        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_max_pairs(8'd255);
        random_phase(30);
        drain();

        src_idle_pct = 8;
        sink_idle_pct = 8;
        write_max_pairs(8'($urandom_range(2, 6)));
        hold_request = 1'b1;
        random_phase(30);
        drain();

        write_max_pairs(8'd3);
        random_phase(30);
        drain();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
src/uqsd_pkg.sv
src/uqsd_front.sv
src/uqsd_queue.sv
src/uqsd_back.sv
src/url_query_string_decoder.sv
tb/sv/testbench.sv
